// File: src/nspc_pkg.sv
// Package for the nested segment packet checker: beat structs, parse phases
// and sizing constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package nspc_pkg;

  // default name length limit (lengths run 1 .. limit-1)
  localparam int NAME_LIMIT_DEF = 64;

  // bytes in one segment record: name byte plus address bytes
  localparam int SEG_ADDR_BYTES  = 4;
  localparam int SEG_TOTAL_BYTES = 1 + SEG_ADDR_BYTES;
  localparam int SEG_CNT_W       = 3;

  // subject, module and segment counts are non-negative signed bytes
  localparam int COUNT_W = 7;

  // input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic packet_ok;
    logic clean_setup;
  } out_beat_t;

  // parse phases
  typedef enum logic [3:0] {
    PH_FLAG       = 4'd0,
    PH_SUBJ_COUNT = 4'd1,
    PH_SUBJ_LEN   = 4'd2,
    PH_SUBJ_NAME  = 4'd3,
    PH_MOD_COUNT  = 4'd4,
    PH_MOD_LEN    = 4'd5,
    PH_MOD_NAME   = 4'd6,
    PH_SEG_COUNT  = 4'd7,
    PH_SEG        = 4'd8,
    PH_CLOSE      = 4'd9,
    PH_AFTER      = 4'd10
  } phase_t;

endpackage

`default_nettype wire

// File: src/nested_segment_packet_check_unit.sv
// Top level of the nested segment packet checker: byte-wise structure parser
// with a registered result beat. Depends on nspc_pkg.
`timescale 1ns / 1ps
`default_nettype none

// channel | ports                        | beat
// --------+------------------------------+-----------------------------------
// input   | in_valid, in_ready, in_data  | one packet byte plus last marker
// result  | out_valid, out_ready, out_data | packet_ok, clean_setup per packet
//
// One byte is taken per cycle; the parse phase and counters update in the
// cycle the byte is accepted. The verdict for a packet is loaded into the result
// register when its last byte is accepted.
// Reset returns the parser to the flag byte phase with the result empty.
// The input stalls only while a verdict is held and the result side is
// not taking it.

module nested_segment_packet_check_unit
  import nspc_pkg::*;
#(
  parameter int NAME_LIMIT = NAME_LIMIT_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  in_beat_t   in_data,
  output logic       out_valid,
  input  wire        out_ready,
  output out_beat_t  out_data
);

  localparam int NAME_W = $clog2(NAME_LIMIT);
  localparam logic [7:0] NameLimitB = 8'(NAME_LIMIT);

  // parser state
  phase_t               phase_r, phase_nxt;
  logic [COUNT_W-1:0]   subj_r, subj_nxt;
  logic [COUNT_W-1:0]   mod_r, mod_nxt;
  logic [COUNT_W-1:0]   seg_r, seg_nxt;
  logic [NAME_W-1:0]    name_r, name_nxt;
  logic [SEG_CNT_W-1:0] segb_r, segb_nxt;
  logic                 failed_r, failed_nxt;
  logic                 clean_r, clean_nxt;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  out_beat_t            out_data_r, out_data_nxt;

  // byte decode
  logic                 in_acc;
  logic [7:0]           b;
  logic                 is_neg;
  logic                 len_ok;
  logic [COUNT_W-1:0]   cnt_val;
  logic                 verdict_ok;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign b       = in_data.data_byte;
  assign is_neg  = b[7];
  assign cnt_val = b[COUNT_W-1:0];
  assign len_ok  = !is_neg && (b != 8'd0) && (b < NameLimitB);

  // next parser state for one accepted byte
  always_comb begin
    phase_t ph;
    logic   fl;
    ph       = phase_r;
    fl       = failed_r;
    subj_nxt = subj_r;
    mod_nxt  = mod_r;
    seg_nxt  = seg_r;
    name_nxt = name_r;
    segb_nxt = segb_r;
    clean_nxt = clean_r;

    if (!failed_r) begin
      case (phase_r)
        PH_FLAG: begin
          if (b > 8'd1) begin
            fl = 1'b1;
          end else begin
            clean_nxt = b[0];
            ph = PH_SUBJ_COUNT;
          end
        end
        PH_SUBJ_COUNT: begin
          if (is_neg) begin
            fl = 1'b1;
          end else begin
            subj_nxt = cnt_val;
            ph = (cnt_val != '0) ? PH_SUBJ_LEN : PH_CLOSE;
          end
        end
        PH_SUBJ_LEN, PH_MOD_LEN: begin
          if (!len_ok) begin
            fl = 1'b1;
          end else begin
            name_nxt = b[NAME_W-1:0];
            ph = (phase_r == PH_SUBJ_LEN) ? PH_SUBJ_NAME : PH_MOD_NAME;
          end
        end
        PH_SUBJ_NAME, PH_MOD_NAME: begin
          name_nxt = name_r - NAME_W'(1);
          if (name_r == NAME_W'(1)) begin
            ph = (phase_r == PH_SUBJ_NAME) ? PH_MOD_COUNT : PH_SEG_COUNT;
          end
        end
        PH_MOD_COUNT: begin
          if (is_neg) begin
            fl = 1'b1;
          end else begin
            mod_nxt = cnt_val;
            if (cnt_val != '0) begin
              ph = PH_MOD_LEN;
            end else begin
              // end of subject
              subj_nxt = subj_r - COUNT_W'(1);
              ph = (subj_r != COUNT_W'(1)) ? PH_SUBJ_LEN : PH_CLOSE;
            end
          end
        end
        PH_SEG_COUNT: begin
          if (is_neg) begin
            fl = 1'b1;
          end else begin
            seg_nxt = cnt_val;
            if (cnt_val != '0) begin
              segb_nxt = SEG_CNT_W'(SEG_TOTAL_BYTES);
              ph = PH_SEG;
            end else begin
              // end of module
              mod_nxt = mod_r - COUNT_W'(1);
              if (mod_r != COUNT_W'(1)) begin
                ph = PH_MOD_LEN;
              end else begin
                subj_nxt = subj_r - COUNT_W'(1);
                ph = (subj_r != COUNT_W'(1)) ? PH_SUBJ_LEN : PH_CLOSE;
              end
            end
          end
        end
        PH_SEG: begin
          segb_nxt = segb_r - SEG_CNT_W'(1);
          if (segb_r == SEG_CNT_W'(1)) begin
            seg_nxt = seg_r - COUNT_W'(1);
            if (seg_r != COUNT_W'(1)) begin
              segb_nxt = SEG_CNT_W'(SEG_TOTAL_BYTES);
            end else begin
              mod_nxt = mod_r - COUNT_W'(1);
              if (mod_r != COUNT_W'(1)) begin
                ph = PH_MOD_LEN;
              end else begin
                subj_nxt = subj_r - COUNT_W'(1);
                ph = (subj_r != COUNT_W'(1)) ? PH_SUBJ_LEN : PH_CLOSE;
              end
            end
          end
        end
        PH_CLOSE: begin
          if (b != 8'd0) begin
            fl = 1'b1;
          end else begin
            ph = PH_AFTER;
          end
        end
        default: begin
          fl = 1'b1;
        end
      endcase
    end

    // closing byte without end marker means trailing bytes
    if (!in_data.last_byte && !fl && ph == PH_AFTER) begin
      fl = 1'b1;
    end

    verdict_ok = !fl && (ph == PH_AFTER);
    phase_nxt  = ph;
    failed_nxt = fl;

    // last byte returns the parser to its start
    if (in_data.last_byte) begin
      phase_nxt  = PH_FLAG;
      failed_nxt = 1'b0;
      subj_nxt   = '0;
      mod_nxt    = '0;
      seg_nxt    = '0;
      name_nxt   = '0;
      segb_nxt   = '0;
      clean_nxt  = 1'b0;
    end
  end

  // result register next value
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (in_acc && in_data.last_byte) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.packet_ok   = verdict_ok;
      out_data_nxt.clean_setup = verdict_ok && (phase_r == PH_FLAG ? b[0] : clean_r);
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FLAG;
      subj_r   <= '0;
      mod_r    <= '0;
      seg_r    <= '0;
      name_r   <= '0;
      segb_r   <= '0;
      failed_r <= 1'b0;
      clean_r  <= 1'b0;
    end else if (in_acc) begin
      phase_r  <= phase_nxt;
      subj_r   <= subj_nxt;
      mod_r    <= mod_nxt;
      seg_r    <= seg_nxt;
      name_r   <= name_nxt;
      segb_r   <= segb_nxt;
      failed_r <= failed_nxt;
      clean_r  <= clean_nxt;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // a failed verdict never reports a clean setup
  a_clean_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.packet_ok || !out_data_r.clean_setup))
    else $error("clean_setup set on failed packet");

  // a byte without end marker never raises a result
  a_no_result_mid_packet: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && in_acc && !in_data.last_byte) |=> !out_valid_r)
    else $error("result raised by non-final byte");

  // the last byte restarts the parser
  a_restart_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.last_byte) |=> (phase_r == PH_FLAG && !failed_r))
    else $error("parser not restarted after last byte");

  // once failed, the phase is frozen until the last byte
  a_frozen_after_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (failed_r && in_acc && !in_data.last_byte) |=> (failed_r && $stable(phase_r)))
    else $error("parser moved after failure");

  // a last byte is accepted only when the result register can take it
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.last_byte) |-> (!out_valid_r || out_ready))
    else $error("result overwritten before taken");

endmodule

`default_nettype wire
